### hdl/cmbh_pkg.sv
// shared types, codes and constants for the coprocessor mailbox boot handler
// no dependencies; used by every module of the block
`default_nettype none

package cmbh_pkg;

    localparam int MSG_W        = 64;
    localparam int EP_W         = 8;
    localparam int VER_W        = 16;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 80;
    localparam int MAP_PAGES    = 8;
    localparam int MAP_PAGE_W   = 32;
    localparam int START_EPS    = 4;
    localparam int FIFO_DEPTH   = 2;

    localparam logic [VER_W-1:0] MIN_VER_RESET = 16'd11;
    localparam logic [VER_W-1:0] MAX_VER_RESET = 16'd12;

    localparam logic [MSG_W-1:0] WAKEUP_MSG = 64'h0060_0000_0000_0220;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VER = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VER = 8'd1;

    // endpoints
    localparam logic [EP_W-1:0] EP_MGMT      = 8'h00;
    localparam logic [EP_W-1:0] EP_CRASHLOG  = 8'h01;
    localparam logic [EP_W-1:0] EP_SYSLOG    = 8'h02;
    localparam logic [EP_W-1:0] EP_IOREPORT  = 8'h04;
    localparam logic [EP_W-1:0] EP_APP_FIRST = 8'h20;

    // management message types
    localparam logic [7:0] MSG_HELLO       = 8'h01;
    localparam logic [7:0] MSG_HELLO_REPLY = 8'h02;
    localparam logic [7:0] MSG_START_EP    = 8'h05;
    localparam logic [7:0] MSG_PWR_ACK     = 8'h07;
    localparam logic [7:0] MSG_EPMAP       = 8'h08;
    localparam logic [7:0] MSG_PWR_STATE   = 8'h0b;

    // endpoint message types
    localparam logic [7:0] EPMSG_BUF_REQ     = 8'h01;
    localparam logic [7:0] EPMSG_SYSLOG_LOG  = 8'h05;
    localparam logic [7:0] EPMSG_SYSLOG_INIT = 8'h08;
    localparam logic [7:0] EPMSG_IOR_ACK     = 8'h08;
    localparam logic [7:0] EPMSG_IOR_UNK     = 8'h0c;

    typedef enum logic [1:0] {
        BOOT_INIT    = 2'd0,
        BOOT_BOOTING = 2'd1,
        BOOT_RUNNING = 2'd2,
        BOOT_FAILED  = 2'd3
    } boot_state_t;

    typedef enum logic [2:0] {
        KIND_SEND        = 3'd0,
        KIND_SET_RUN     = 3'd1,
        KIND_TO_CLIENT   = 3'd2,
        KIND_BUF_REQ     = 3'd3,
        KIND_BOOT_OK     = 3'd4,
        KIND_BOOT_FAILED = 3'd5,
        KIND_CRASHED     = 3'd6
    } out_kind_t;

    // one queued job: first result plus the system endpoints still to start
    typedef struct packed {
        out_kind_t              kind;
        logic [EP_W-1:0]        ep;
        logic [MSG_W-1:0]       msg;
        logic                   bad;
        logic [START_EPS-1:0]   start_mask;
    } cmd_t;

endpackage

`default_nettype wire

### hdl/cmbh_front.sv
// front end: accepts beats, decodes them, keeps the boot state and the endpoint map
// depends on cmbh_pkg
`default_nettype none

module cmbh_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [cmbh_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cmbh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cmbh_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output cmbh_pkg::cmd_t                         q_cmd
);

    cmbh_pkg::boot_state_t state_reg, state_next;
    logic [cmbh_pkg::VER_W-1:0] min_ver_reg, max_ver_reg;
    logic crash_known_reg, crash_known_next;
    logic [7:0] log_count_reg, log_count_next;
    logic [cmbh_pkg::MAP_PAGE_W-1:0] map_reg  [cmbh_pkg::MAP_PAGES];
    logic [cmbh_pkg::MAP_PAGE_W-1:0] map_next [cmbh_pkg::MAP_PAGES];

    logic                           in_fire;
    logic                           running;
    logic [cmbh_pkg::EP_W-1:0]      ep;
    logic [cmbh_pkg::MSG_W-1:0]     msg;
    logic [7:0]                     msg_type;
    logic [cmbh_pkg::VER_W-1:0]     ver_lo, ver_hi, ver_want;
    logic [2:0]                     base;
    logic                           last_page;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;

    assign running   = s_tdata[0];
    assign ep        = s_tdata[8:1];
    assign msg       = s_tdata[72:9];
    assign msg_type  = msg[59:52];
    assign ver_lo    = msg[15:0];
    assign ver_hi    = msg[31:16];
    assign ver_want  = (ver_hi < max_ver_reg) ? ver_hi : max_ver_reg;
    assign base      = msg[34:32];
    assign last_page = msg[51];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= cmbh_pkg::BOOT_INIT;
            crash_known_reg <= 1'b0;
            log_count_reg   <= '0;
            min_ver_reg     <= cmbh_pkg::MIN_VER_RESET;
            max_ver_reg     <= cmbh_pkg::MAX_VER_RESET;
            for (int i = 0; i < cmbh_pkg::MAP_PAGES; i++) begin
                map_reg[i] <= '0;
            end
        end else begin
            state_reg       <= state_next;
            crash_known_reg <= crash_known_next;
            log_count_reg   <= log_count_next;
            map_reg         <= map_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == cmbh_pkg::CFG_MIN_VER) begin
                    min_ver_reg <= cfg_data;
                end else if (cfg_index == cmbh_pkg::CFG_MAX_VER) begin
                    max_ver_reg <= cfg_data;
                end
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        crash_known_next = crash_known_reg;
        log_count_next   = log_count_reg;
        map_next         = map_reg;
        q_push           = 1'b0;
        q_cmd            = '0;
        if (in_fire) begin
            if (!s_tuser) begin
                if (state_reg == cmbh_pkg::BOOT_INIT) begin
                    state_next = cmbh_pkg::BOOT_BOOTING;
                    q_push     = 1'b1;
                    if (running) begin
                        q_cmd.kind = cmbh_pkg::KIND_SEND;
                        q_cmd.msg  = cmbh_pkg::WAKEUP_MSG;
                    end else begin
                        q_cmd.kind = cmbh_pkg::KIND_SET_RUN;
                    end
                end
            end else begin
                case (ep)
                    cmbh_pkg::EP_MGMT: begin
                        case (msg_type)
                            cmbh_pkg::MSG_HELLO: begin
                                q_push = 1'b1;
                                if (ver_lo > max_ver_reg || ver_hi < min_ver_reg) begin
                                    state_next = cmbh_pkg::BOOT_FAILED;
                                    q_cmd.kind = cmbh_pkg::KIND_BOOT_FAILED;
                                end else begin
                                    q_cmd.kind = cmbh_pkg::KIND_SEND;
                                    q_cmd.msg  = {4'b0, cmbh_pkg::MSG_HELLO_REPLY, 20'b0,
                                                  ver_want, ver_want};
                                end
                            end
                            cmbh_pkg::MSG_EPMAP: begin
                                map_next[base] = map_reg[base] | msg[31:0];
                                q_push     = 1'b1;
                                q_cmd.kind = cmbh_pkg::KIND_SEND;
                                q_cmd.msg  = {4'b0, cmbh_pkg::MSG_EPMAP, last_page, 16'b0,
                                              base, 31'b0, !last_page};
                                // last page starts the system endpoints found in page 0
                                if (last_page) begin
                                    q_cmd.start_mask = map_next[0][cmbh_pkg::START_EPS:1];
                                end
                            end
                            cmbh_pkg::MSG_PWR_ACK: begin
                                q_push     = 1'b1;
                                q_cmd.kind = cmbh_pkg::KIND_SEND;
                                q_cmd.msg  = {4'b0, cmbh_pkg::MSG_PWR_STATE, 52'h20};
                            end
                            cmbh_pkg::MSG_PWR_STATE: begin
                                state_next = cmbh_pkg::BOOT_RUNNING;
                                q_push     = 1'b1;
                                q_cmd.kind = cmbh_pkg::KIND_BOOT_OK;
                            end
                            default: begin
                            end
                        endcase
                    end
                    cmbh_pkg::EP_CRASHLOG: begin
                        if (msg_type == cmbh_pkg::EPMSG_BUF_REQ) begin
                            q_push = 1'b1;
                            if (!crash_known_reg) begin
                                crash_known_next = 1'b1;
                                q_cmd.kind = cmbh_pkg::KIND_BUF_REQ;
                                q_cmd.ep   = ep;
                                q_cmd.msg  = msg;
                            end else begin
                                q_cmd.kind = cmbh_pkg::KIND_CRASHED;
                            end
                        end
                    end
                    cmbh_pkg::EP_SYSLOG: begin
                        case (msg_type)
                            cmbh_pkg::EPMSG_BUF_REQ: begin
                                q_push     = 1'b1;
                                q_cmd.kind = cmbh_pkg::KIND_BUF_REQ;
                                q_cmd.ep   = ep;
                                q_cmd.msg  = msg;
                            end
                            cmbh_pkg::EPMSG_SYSLOG_INIT: begin
                                log_count_next = msg[7:0];
                            end
                            cmbh_pkg::EPMSG_SYSLOG_LOG: begin
                                q_push     = 1'b1;
                                q_cmd.kind = cmbh_pkg::KIND_SEND;
                                q_cmd.ep   = ep;
                                q_cmd.msg  = msg;
                                q_cmd.bad  = msg[7:0] > log_count_reg;
                            end
                            default: begin
                            end
                        endcase
                    end
                    cmbh_pkg::EP_IOREPORT: begin
                        case (msg_type) inside
                            cmbh_pkg::EPMSG_BUF_REQ: begin
                                q_push     = 1'b1;
                                q_cmd.kind = cmbh_pkg::KIND_BUF_REQ;
                                q_cmd.ep   = ep;
                                q_cmd.msg  = msg;
                            end
                            cmbh_pkg::EPMSG_IOR_ACK, cmbh_pkg::EPMSG_IOR_UNK: begin
                                q_push     = 1'b1;
                                q_cmd.kind = cmbh_pkg::KIND_SEND;
                                q_cmd.ep   = ep;
                                q_cmd.msg  = msg;
                            end
                            default: begin
                            end
                        endcase
                    end
                    default: begin
                        if (ep >= cmbh_pkg::EP_APP_FIRST) begin
                            q_push     = 1'b1;
                            q_cmd.kind = cmbh_pkg::KIND_TO_CLIENT;
                            q_cmd.ep   = ep;
                            q_cmd.msg  = msg;
                        end
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### hdl/cmbh_fifo.sv
// small job queue between the front and back ends, first word fall-through
// depends on cmbh_pkg
`default_nettype none

module cmbh_fifo #(
    parameter int DEPTH = cmbh_pkg::FIFO_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  cmbh_pkg::cmd_t       push_data,
    output logic                 full,
    input  wire logic            pop,
    output cmbh_pkg::cmd_t       pop_data,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmbh_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/cmbh_back.sv
// back end: turns queued jobs into result beats, one per cycle while m_tready is high, behind an output register
// depends on cmbh_pkg
`default_nettype none

module cmbh_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  cmbh_pkg::cmd_t                       q_cmd,
    input  wire logic                            q_empty,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [cmbh_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [2:0]                           m_tuser,
    output logic                                 m_tlast
);

    logic                               valid_reg, valid_next;
    cmbh_pkg::out_kind_t                kind_reg, kind_next;
    logic [cmbh_pkg::EP_W-1:0]          ep_reg, ep_next;
    logic [cmbh_pkg::MSG_W-1:0]         msg_reg, msg_next;
    logic                               bad_reg, bad_next;
    logic                               last_reg, last_next;
    logic [cmbh_pkg::START_EPS-1:0]     rem_reg, rem_next;
    logic [cmbh_pkg::START_EPS-1:0]     rem_clr;
    logic [1:0]                         sel;
    logic                               load;

    assign load = !valid_reg || m_tready;

    // lowest pending system endpoint
    always_comb begin
        sel = '0;
        for (int i = cmbh_pkg::START_EPS - 1; i >= 0; i--) begin
            if (rem_reg[i]) begin
                sel = 2'(i);
            end
        end
        rem_clr      = rem_reg;
        rem_clr[sel] = 1'b0;
    end

    always_comb begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        ep_next    = ep_reg;
        msg_next   = msg_reg;
        bad_next   = bad_reg;
        last_next  = last_reg;
        rem_next   = rem_reg;
        q_pop      = 1'b0;
        if (load) begin
            if (rem_reg != '0) begin
                valid_next = 1'b1;
                kind_next  = cmbh_pkg::KIND_SEND;
                ep_next    = cmbh_pkg::EP_MGMT;
                msg_next   = {4'b0, cmbh_pkg::MSG_START_EP, 17'b0,
                              {1'b0, sel} + 3'd1, 32'd2};
                bad_next   = 1'b0;
                last_next  = (rem_clr == '0);
                rem_next   = rem_clr;
            end else if (!q_empty) begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                kind_next  = q_cmd.kind;
                ep_next    = q_cmd.ep;
                msg_next   = q_cmd.msg;
                bad_next   = q_cmd.bad;
                last_next  = (q_cmd.start_mask == '0);
                rem_next   = q_cmd.start_mask;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        ep_reg   <= ep_next;
        msg_reg  <= msg_next;
        bad_reg  <= bad_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {7'b0, bad_reg, msg_reg, ep_reg};

endmodule

`default_nettype wire

### hdl/coprocessor_mailbox_boot_handler.sv
// top level of the coprocessor mailbox boot handler: front end, job queue, back end
// depends on cmbh_pkg, cmbh_front, cmbh_fifo, cmbh_back
//
// usage
//   s_* channel: one beat is a boot request (s_tuser = 0) or an inbound mailbox
//     message (s_tuser = 1). the beat is decoded and the boot state, endpoint
//     map, crash-buffer flag and syslog entry count are updated in the cycle it
//     is accepted. beats that cause no result are simply absorbed.
//   m_* channel: result beats in order; m_tlast marks the final result of an
//     input beat. most inputs give one result, the last endpoint-map page gives
//     its ack followed by a start message per system endpoint 1..4 set in page 0.
//   cfg_* channel: always ready; index 0 min version, index 1 max version,
//     other indexes are ignored. write only while the block is idle.
// timing
//   each job is registered in the job queue and then in the output register.
//   input beats are accepted one per cycle while the job queue has room; the
//   output register drains one beat per cycle while m_tready is high. the queue
//   depth (FIFO_DEPTH jobs) sets how far the front end runs ahead of a stalled
//   receiver; once it fills, s_tready drops.
// reset
//   synchronous active-low aresetn clears boot state, endpoint map, flags, queue
//   and output valid, and reloads the version range 11..12.
`default_nettype none

module coprocessor_mailbox_boot_handler #(
    parameter int FIFO_DEPTH = cmbh_pkg::FIFO_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input beats
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [0] cpu_running, [8:1] endpoint, [72:9] message, [79:73] zero
    input  wire logic [cmbh_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] action
    input  wire logic                              s_tuser,
    // result beats
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] out_endpoint, [71:8] out_message, [72] syslog_index_bad, [79:73] zero
    output logic [cmbh_pkg::M_TDATA_W-1:0]         m_tdata,
    // [2:0] out_kind
    output logic [2:0]                             m_tuser,
    output logic                                   m_tlast,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cmbh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cmbh_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // job queue handshake between the two halves
    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    cmbh_pkg::cmd_t push_cmd;
    cmbh_pkg::cmd_t head_cmd;

    // decode, state update and job build
    cmbh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // decouples a stalled receiver from the decoder
    cmbh_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_cmd),
        .empty     (q_empty)
    );

    // expands each job into its result beats
    cmbh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_cmd    (head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench for the coprocessor mailbox boot handler
// depends on cmbh_pkg and coprocessor_mailbox_boot_handler; a directed table, then random traffic
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import cmbh_pkg::*;

    // one input beat, with an optional hand-written expected reply
    typedef struct {
        bit               action;
        bit               running;
        logic [EP_W-1:0]  ep;
        logic [MSG_W-1:0] msg;
        bit               typed;
        out_kind_t        x_kind;
        logic [EP_W-1:0]  x_ep;
        logic [MSG_W-1:0] x_msg;
        bit               x_bad;
    } mailbox_beat_t;

    // one result beat as seen on m_*
    typedef struct packed {
        out_kind_t        kind;
        logic [EP_W-1:0]  ep;
        logic [MSG_W-1:0] msg;
        logic             bad;
        logic             last;
    } host_reply_t;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 60;
    localparam int PHASE_ITEMS   = 39;
    localparam int REPORT_LIMIT  = 10;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    coprocessor_mailbox_boot_handler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // [0] cpu_running, [8:1] endpoint, [72:9] message, [79:73] zero
        .s_tdata   (s_tdata),
        // [0] action
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [7:0] out_endpoint, [71:8] out_message, [72] syslog_index_bad, [79:73] zero
        .m_tdata   (m_tdata),
        // [2:0] out_kind
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // host-side mirror of the block state and version range
    boot_state_t            host_boot;
    logic [VER_W-1:0]       host_min_ver;
    logic [VER_W-1:0]       host_max_ver;
    logic [VER_W-1:0]       host_version;
    logic [MAP_PAGE_W-1:0]  host_ep_map [MAP_PAGES];
    bit                     host_crash_known;
    logic [7:0]             host_log_count;

    host_reply_t   beat_replies[$];     // replies of the beat just predicted
    host_reply_t   pending_replies[$];  // replies still owed by the block
    mailbox_beat_t directed_rows[$];

    int  fail_count   = 0;
    int  report_count = 0;
    bit  tx_steady    = 1'b0;   // sender offers back to back
    bit  rx_steady    = 1'b0;   // receiver always ready
    bit  rx_hold_req  = 1'b0;   // receiver holds off for a long stretch

    function automatic logic [MSG_W-1:0] with_type(input logic [7:0] t,
                                                   input logic [MSG_W-1:0] body);
        logic [MSG_W-1:0] m;
        m = body;
        m[59:52] = t;
        return m;
    endfunction

    function automatic void add_reply(input out_kind_t kind, input logic [EP_W-1:0] ep,
                                      input logic [MSG_W-1:0] msg, input logic bad);
        host_reply_t r;
        r.kind = kind;
        r.ep   = ep;
        r.msg  = msg;
        r.bad  = bad;
        r.last = 1'b0;
        beat_replies.push_back(r);
    endfunction

    // management endpoint: version handshake, endpoint map, power states
    task automatic handle_mgmt(input logic [MSG_W-1:0] m);
        logic [VER_W-1:0]      lo;
        logic [VER_W-1:0]      hi;
        logic [2:0]            base;
        logic [MSG_W-1:0]      ack;
        lo = m[15:0];
        hi = m[31:16];
        base = m[34:32];
        case (m[59:52])
            MSG_HELLO: begin
                if (lo > host_max_ver || hi < host_min_ver) begin
                    host_boot = BOOT_FAILED;
                    add_reply(KIND_BOOT_FAILED, '0, '0, 1'b0);
                end else begin
                    host_version = (hi < host_max_ver) ? hi : host_max_ver;
                    add_reply(KIND_SEND, EP_MGMT,
                              with_type(MSG_HELLO_REPLY, {32'h0, host_version, host_version}),
                              1'b0);
                end
            end
            MSG_EPMAP: begin
                host_ep_map[base] = host_ep_map[base] | m[31:0];
                ack = 64'(base) << 32;
                ack = ack | (m[51] ? (64'h1 << 51) : 64'h1);
                add_reply(KIND_SEND, EP_MGMT, with_type(MSG_EPMAP, ack), 1'b0);
                // last page: start the system endpoints present in page 0
                if (m[51]) begin
                    for (int e = 1; e <= START_EPS; e++) begin
                        if (host_ep_map[0][e])
                            add_reply(KIND_SEND, EP_MGMT,
                                      with_type(MSG_START_EP, (64'(e) << 32) | 64'h2), 1'b0);
                    end
                end
            end
            MSG_PWR_ACK: begin
                add_reply(KIND_SEND, EP_MGMT, with_type(MSG_PWR_STATE, 64'h20), 1'b0);
            end
            MSG_PWR_STATE: begin
                host_boot = BOOT_RUNNING;
                add_reply(KIND_BOOT_OK, '0, '0, 1'b0);
            end
            default: ;
        endcase
    endtask

    // work out the replies that one accepted beat causes
    task automatic handle_mailbox_beat(input mailbox_beat_t it);
        logic [7:0] mtype;
        mtype = it.msg[59:52];
        beat_replies.delete();
        if (!it.action) begin
            if (host_boot == BOOT_INIT) begin
                host_boot = BOOT_BOOTING;
                if (it.running)
                    add_reply(KIND_SEND, EP_MGMT, WAKEUP_MSG, 1'b0);
                else
                    add_reply(KIND_SET_RUN, '0, '0, 1'b0);
            end
        end else if (it.ep == EP_MGMT) begin
            handle_mgmt(it.msg);
        end else if (it.ep == EP_CRASHLOG) begin
            if (mtype == EPMSG_BUF_REQ) begin
                if (!host_crash_known) begin
                    host_crash_known = 1'b1;
                    add_reply(KIND_BUF_REQ, EP_CRASHLOG, it.msg, 1'b0);
                end else begin
                    add_reply(KIND_CRASHED, '0, '0, 1'b0);
                end
            end
        end else if (it.ep == EP_SYSLOG) begin
            if (mtype == EPMSG_BUF_REQ)
                add_reply(KIND_BUF_REQ, EP_SYSLOG, it.msg, 1'b0);
            else if (mtype == EPMSG_SYSLOG_INIT)
                host_log_count = it.msg[7:0];
            else if (mtype == EPMSG_SYSLOG_LOG)
                add_reply(KIND_SEND, EP_SYSLOG, it.msg, it.msg[7:0] > host_log_count);
        end else if (it.ep == EP_IOREPORT) begin
            if (mtype == EPMSG_BUF_REQ)
                add_reply(KIND_BUF_REQ, EP_IOREPORT, it.msg, 1'b0);
            else if (mtype == EPMSG_IOR_ACK || mtype == EPMSG_IOR_UNK)
                add_reply(KIND_SEND, EP_IOREPORT, it.msg, 1'b0);
        end else if (it.ep >= EP_APP_FIRST) begin
            add_reply(KIND_TO_CLIENT, it.ep, it.msg, 1'b0);
        end
        if (beat_replies.size() > 0)
            beat_replies[beat_replies.size()-1].last = 1'b1;
    endtask

    // offer one beat after a random gap, then book its replies
    task automatic send_beat(input mailbox_beat_t it);
        int          gap;
        host_reply_t r;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {7'h0, it.msg, it.ep, it.running};
        do @(posedge aclk); while (!s_tready);
        handle_mailbox_beat(it);
        if (it.typed) begin
            r.kind = it.x_kind;
            r.ep   = it.x_ep;
            r.msg  = it.x_msg;
            r.bad  = it.x_bad;
            r.last = 1'b1;
            pending_replies.push_back(r);
        end else begin
            foreach (beat_replies[i])
                pending_replies.push_back(beat_replies[i]);
        end
    endtask

    // stop offering, let every owed reply arrive, then let the pipe settle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_MIN_VER)
            host_min_ver = val;
        else if (idx == CFG_MAX_VER)
            host_max_ver = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // versions near the configured range, sometimes anywhere
    function automatic logic [VER_W-1:0] pick_version();
        case ($urandom_range(0, 4))
            0: return host_min_ver;
            1: return host_max_ver;
            2: return host_min_ver - 16'd1;
            3: return host_max_ver + 16'd1;
            default: return VER_W'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_type(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        case ($urandom_range(0, 4))
            0, 1: return a;
            2: return b;
            3: return c;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly well-formed traffic per endpoint, with some noise and stray boot requests
    task automatic make_random_beat(output mailbox_beat_t it);
        int               pick;
        logic [MSG_W-1:0] body;
        body = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        it.action  = 1'b1;
        it.running = 1'($urandom);
        it.typed   = 1'b0;
        it.x_kind  = KIND_SEND;
        it.x_ep    = '0;
        it.x_msg   = '0;
        it.x_bad   = 1'b0;
        if (pick < 30) begin
            it.ep = EP_MGMT;
            case ($urandom_range(0, 4))
                0, 1: begin
                    body[31:0] = {pick_version(), pick_version()};
                    it.msg = with_type(MSG_HELLO, body);
                end
                2: begin
                    body[51] = ($urandom_range(0, 3) == 0);
                    it.msg = with_type(MSG_EPMAP, body);
                end
                3: it.msg = with_type(($urandom_range(0, 1) != 0) ? MSG_PWR_ACK
                                                                   : MSG_PWR_STATE, body);
                default: it.msg = body;
            endcase
        end else if (pick < 40) begin
            it.ep  = EP_CRASHLOG;
            it.msg = with_type(pick_type(EPMSG_BUF_REQ, EPMSG_BUF_REQ, 8'h00), body);
        end else if (pick < 58) begin
            it.ep = EP_SYSLOG;
            if ($urandom_range(0, 1) != 0)
                body[7:0] = host_log_count + 8'($urandom_range(0, 2)) - 8'd1;
            it.msg = with_type(pick_type(EPMSG_SYSLOG_LOG, EPMSG_SYSLOG_INIT, EPMSG_BUF_REQ),
                               body);
        end else if (pick < 68) begin
            it.ep  = EP_IOREPORT;
            it.msg = with_type(pick_type(EPMSG_IOR_ACK, EPMSG_IOR_UNK, EPMSG_BUF_REQ), body);
        end else if (pick < 85) begin
            it.ep  = 8'($urandom_range(32, 255));
            it.msg = body;
        end else if (pick < 95) begin
            // endpoints with no handler
            it.ep  = ($urandom_range(0, 2) == 0) ? 8'h03 : 8'($urandom_range(5, 31));
            it.msg = body;
        end else begin
            it.action = 1'b0;
            it.ep     = 8'($urandom);
            it.msg    = body;
        end
    endtask

    // directed rows: expected reply typed in where it is obvious
    initial begin
        // boot request straight after reset wakes a running coprocessor
        directed_rows.push_back('{1'b0, 1'b1, EP_MGMT, WAKEUP_MSG,
                                  1'b1, KIND_SEND, EP_MGMT, WAKEUP_MSG, 1'b0});
        // second boot request is ignored
        directed_rows.push_back('{1'b0, 1'b0, EP_MGMT, 64'h0,
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        // hello inside the reset range 11..12
        directed_rows.push_back('{1'b1, 1'b0, EP_MGMT, with_type(MSG_HELLO, 64'h000c_000b),
                                  1'b1, KIND_SEND, EP_MGMT,
                                  with_type(MSG_HELLO_REPLY, 64'h000c_000c), 1'b0});
        // hello range below the host range, an unknown mgmt type, then a hello range covering it
        directed_rows.push_back('{1'b1, 1'b1, EP_MGMT, with_type(MSG_HELLO, 64'h0),
                                  1'b1, KIND_BOOT_FAILED, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b1, EP_MGMT, 64'hffff_ffff_ffff_ffff,
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_MGMT,
                                  with_type(MSG_HELLO, 64'hf00f_ffff_ffff_0000),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        // endpoint map: plain page, full last page, empty last page
        directed_rows.push_back('{1'b1, 1'b0, EP_MGMT, with_type(MSG_EPMAP, 64'h1e),
                                  1'b1, KIND_SEND, EP_MGMT, with_type(MSG_EPMAP, 64'h1), 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_MGMT,
                                  with_type(MSG_EPMAP, 64'h0008_0007_ffff_ffff),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_MGMT,
                                  with_type(MSG_EPMAP, 64'h0008_0000_0000_0000),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        // both boot-done stages
        directed_rows.push_back('{1'b1, 1'b1, EP_MGMT,
                                  with_type(MSG_PWR_ACK, 64'hffff_ffff_ffff_ffff),
                                  1'b1, KIND_SEND, EP_MGMT, with_type(MSG_PWR_STATE, 64'h20),
                                  1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_MGMT, with_type(MSG_PWR_STATE, 64'h0),
                                  1'b1, KIND_BOOT_OK, '0, '0, 1'b0});
        // crashlog: first gives a buffer request, then crashed, unknown type ignored
        directed_rows.push_back('{1'b1, 1'b0, EP_CRASHLOG,
                                  with_type(EPMSG_BUF_REQ, 64'h0123_4567_89ab_cdef),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_CRASHLOG, with_type(EPMSG_BUF_REQ, 64'h0),
                                  1'b1, KIND_CRASHED, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_CRASHLOG, 64'h0,
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        // syslog: entry count 5, then index at, above and far above it, then a buffer request
        directed_rows.push_back('{1'b1, 1'b0, EP_SYSLOG, with_type(EPMSG_SYSLOG_INIT, 64'h05),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_SYSLOG, with_type(EPMSG_SYSLOG_LOG, 64'h05),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_SYSLOG, with_type(EPMSG_SYSLOG_LOG, 64'h06),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b1, EP_SYSLOG,
                                  with_type(EPMSG_SYSLOG_LOG, 64'hffff_ffff_ffff_ffff),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_SYSLOG, with_type(EPMSG_BUF_REQ, 64'h77),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        // ioreport: buffer request, both echoed types, unknown type
        directed_rows.push_back('{1'b1, 1'b0, EP_IOREPORT, with_type(EPMSG_BUF_REQ, 64'h10),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_IOREPORT, with_type(EPMSG_IOR_ACK, 64'h11),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_IOREPORT, with_type(EPMSG_IOR_UNK, 64'h12),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_IOREPORT, with_type(8'hff, 64'h13),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        // endpoints with no handler, then both ends of the app range
        directed_rows.push_back('{1'b1, 1'b0, 8'h03, with_type(EPMSG_BUF_REQ, 64'h0),
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, 8'h1f, 64'h0,
                                  1'b0, KIND_SEND, '0, '0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b0, EP_APP_FIRST, 64'h0,
                                  1'b1, KIND_TO_CLIENT, EP_APP_FIRST, 64'h0, 1'b0});
        directed_rows.push_back('{1'b1, 1'b1, 8'hff, 64'hffff_ffff_ffff_ffff,
                                  1'b1, KIND_TO_CLIENT, 8'hff, 64'hffff_ffff_ffff_ffff, 1'b0});
    end

    // main sequence: reset, directed table, then random phases over several version ranges
    initial begin
        logic [VER_W-1:0] phase_min [5];
        logic [VER_W-1:0] phase_max [5];
        mailbox_beat_t    it;
        int               done;
        host_boot        = BOOT_INIT;
        host_min_ver     = MIN_VER_RESET;
        host_max_ver     = MAX_VER_RESET;
        host_version     = '0;
        host_crash_known = 1'b0;
        host_log_count   = '0;
        foreach (host_ep_map[i])
            host_ep_map[i] = '0;
        // extremes, equal bounds, an inverted range and one drawn at random
        phase_min = '{16'h0000, 16'hffff, 16'h0000, 16'h0100, 16'h0000};
        phase_max = '{16'hffff, 16'hffff, 16'h0000, 16'h0008, 16'h0000};
        phase_min[4] = VER_W'($urandom_range(0, 40));
        phase_max[4] = phase_min[4] + VER_W'($urandom_range(0, 8));

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        for (int p = 0; p < 5; p++) begin
            // the sender pauses here until every owed reply is back
            wait_idle();
            write_reg(CFG_MIN_VER, phase_min[p]);
            write_reg(CFG_MAX_VER, phase_max[p]);
            tx_steady = (p == 1) || (p == 2);
            rx_steady = (p == 3);
            // receiver stalls a long time while the sender keeps offering
            if (p == 2)
                rx_hold_req = 1'b1;
            done = 0;
            while (done < PHASE_ITEMS) begin
                make_random_beat(it);
                send_beat(it);
                done++;
            end
        end

        wait_idle();
        fail_count += pending_replies.size();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // receiver: random ready gaps per beat (none while rx_steady), plus one long hold-off
    initial begin
        int gap;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = rx_steady ? 0 : $urandom_range(0, 8);
            repeat (gap) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid && m_tready));
        end
    end

    // compare every accepted result beat with the oldest owed reply
    always @(posedge aclk) begin
        host_reply_t got;
        host_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = out_kind_t'(m_tuser);
            got.ep   = m_tdata[7:0];
            got.msg  = m_tdata[71:8];
            got.bad  = m_tdata[72];
            got.last = m_tlast;
            if (pending_replies.size() == 0) begin
                fail_count++;
                if (report_count < REPORT_LIMIT) begin
                    report_count++;
                    $display("unexpected beat: kind %0d ep %02h msg %016h bad %0b last %0b",
                             m_tuser, got.ep, got.msg, got.bad, got.last);
                end
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (report_count < REPORT_LIMIT) begin
                        report_count++;
                        $display("mismatch: expected kind %0d ep %02h msg %016h bad %0b last %0b",
                                 want.kind, want.ep, want.msg, want.bad, want.last);
                        $display("          actual   kind %0d ep %02h msg %016h bad %0b last %0b",
                                 m_tuser, got.ep, got.msg, got.bad, got.last);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
